// ----- rtl/avfc_pkg.sv -----
// Shared types, widths, codes and reset values of the audio frame viseme classifier.
`default_nettype none

package avfc_pkg;

    // Field and accumulator widths
    localparam int SAMPLE_W   = 16;
    localparam int MAGN_W     = 16;
    localparam int COUNT_W    = 13;
    localparam int SQ_SUM_W   = 43;
    localparam int MAG_SUM_W  = 28;
    localparam int IW_SUM_W   = 40;
    localparam int LEVEL_W    = 15;
    localparam int LIMIT_W    = 16;
    localparam int GAIN_W     = 4;
    localparam int WEIGHT_W   = 16;
    localparam int VISEME_W   = 3;
    localparam int SQ_PROD_W  = 2 * MAGN_W - 1;
    localparam int IW_PROD_W  = MAGN_W + COUNT_W;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Frame math
    localparam int NM_W        = COUNT_W + MAG_SUM_W;
    localparam int PROD_W      = LIMIT_W + NM_W;
    localparam int FRAC_SHIFT  = 16;
    localparam int ROOT_W      = 16;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int DIV_STEPS   = SQ_SUM_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int STEP_CNT_W  = 6;
    localparam int TEST_CNT    = 4;
    localparam int TEST_W      = 2;
    localparam int GAIN_PROD_W = GAIN_W + ROOT_W;
    localparam int WEIGHT_ONE  = 32768;

    // Defaults of the top-level parameters
    localparam int FRAME_MAX_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [LEVEL_W-1:0] SILENCE_LEVEL_RST  = 15'd328;
    localparam logic [LIMIT_W-1:0] LIMIT_OPEN_RST     = 16'd13107;
    localparam logic [LIMIT_W-1:0] LIMIT_MID_RST      = 16'd22938;
    localparam logic [LIMIT_W-1:0] LIMIT_ROUND_RST    = 16'd29491;
    localparam logic [LIMIT_W-1:0] CROSSING_LIMIT_RST = 16'd26214;
    localparam logic [GAIN_W-1:0]  WEIGHT_GAIN_RST    = 4'd5;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_LEVEL  = 3'd0,
        CFG_LIMIT_OPEN     = 3'd1,
        CFG_LIMIT_MID      = 3'd2,
        CFG_LIMIT_ROUND    = 3'd3,
        CFG_CROSSING_LIMIT = 3'd4,
        CFG_WEIGHT_GAIN    = 3'd5
    } t_cfg_index;

    // Result classes
    typedef enum logic [VISEME_W-1:0] {
        VIS_SILENCE = 3'd0,
        VIS_AA      = 3'd1,
        VIS_E       = 3'd2,
        VIS_O       = 3'd3,
        VIS_SS      = 3'd4,
        VIS_I       = 3'd5
    } t_viseme;

    // Classification tests in evaluation order
    typedef enum logic [TEST_W-1:0] {
        TST_OPEN     = 2'd0,
        TST_MID      = 2'd1,
        TST_ROUND    = 2'd2,
        TST_CROSSING = 2'd3
    } t_test;

    // Configuration registers
    typedef struct packed {
        logic [LEVEL_W-1:0] silence_level;
        logic [LIMIT_W-1:0] limit_open;
        logic [LIMIT_W-1:0] limit_mid;
        logic [LIMIT_W-1:0] limit_round;
        logic [LIMIT_W-1:0] crossing_limit;
        logic [GAIN_W-1:0]  weight_gain;
    } t_cfg;

    // Totals of one closed frame
    typedef struct packed {
        logic [COUNT_W-1:0]   n;
        logic [SQ_SUM_W-1:0]  sq_sum;
        logic [MAG_SUM_W-1:0] mag_sum;
        logic [IW_SUM_W-1:0]  iw_sum;
        logic [COUNT_W-1:0]   cross_count;
    } t_frame_sum;

    // Frame math sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_NM,
        ST_MULT,
        ST_TEST,
        ST_FINAL
    } t_back_state;

endpackage

`default_nettype wire

// ----- rtl/avfc_front.sv -----
// Front end: per-sample accumulation of frame statistics, one sample per cycle while the frame queue has room.
`default_nettype none

module avfc_front #(
    parameter int FRAME_MAX   = avfc_pkg::FRAME_MAX_DEF,
    parameter int QUEUE_DEPTH = avfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [avfc_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                                  i_last,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]      i_queue_count,
    output logic                                       o_push,
    output avfc_pkg::t_frame_sum                       o_sum
);
    import avfc_pkg::*;

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                 w_accept;
    logic                 w_close;
    logic                 w_cross;
    logic [MAGN_W-1:0]    w_mag;
    logic [QCNT_W:0]      w_pending;

    logic [COUNT_W-1:0]   r_count;
    logic [SAMPLE_W-1:0]  r_prev;

    logic                 r_s1_valid;
    logic                 r_s1_close;
    logic                 r_s1_cross;
    logic [MAGN_W-1:0]    r_s1_mag;
    logic [COUNT_W-1:0]   r_s1_idx;

    logic                 r_s2_valid;
    logic                 r_s2_close;
    logic                 r_s2_cross;
    logic [MAGN_W-1:0]    r_s2_mag;
    logic [SQ_PROD_W-1:0] r_s2_sq;
    logic [IW_PROD_W-1:0] r_s2_iw;
    logic [COUNT_W-1:0]   r_s2_idx;

    logic [SQ_SUM_W-1:0]  r_sq_sum;
    logic [MAG_SUM_W-1:0] r_mag_sum;
    logic [IW_SUM_W-1:0]  r_iw_sum;
    logic [COUNT_W-1:0]   r_cross_count;

    logic [SQ_SUM_W-1:0]  n_sq_sum;
    logic [MAG_SUM_W-1:0] n_mag_sum;
    logic [IW_SUM_W-1:0]  n_iw_sum;
    logic [COUNT_W-1:0]   n_cross_count;

    // Hold off input while every queue slot is taken or claimed by a closing frame in flight.
    assign w_pending = (QCNT_W+1)'(i_queue_count) + (QCNT_W+1)'(r_s1_close)
                     + (QCNT_W+1)'(r_s2_close);
    assign o_ready   = (w_pending < (QCNT_W+1)'(QUEUE_DEPTH));
    assign w_accept  = i_valid && o_ready;

    // Magnitude, sign change against the previous sample, and frame close.
    assign w_mag   = i_sample[SAMPLE_W-1] ? MAGN_W'($unsigned(-i_sample))
                                          : MAGN_W'($unsigned(i_sample));
    assign w_cross = (r_count != '0)
                  && ((r_prev[SAMPLE_W-1] && !i_sample[SAMPLE_W-1] && (i_sample != '0))
                   || (!r_prev[SAMPLE_W-1] && (r_prev != '0) && i_sample[SAMPLE_W-1]));
    assign w_close = i_last || (r_count == COUNT_W'(FRAME_MAX - 1));

    // Sample index within the frame and the previous sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= '0;
        end else if (w_accept) begin
            r_count <= w_close ? '0 : r_count + COUNT_W'(1);
            r_prev  <= i_sample;
        end
    end

    // Stage one: register the per-sample terms.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_close <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s1_close <= w_accept && w_close;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cross <= w_cross;
        r_s1_mag   <= w_mag;
        r_s1_idx   <= r_count;
    end

    // Stage two: square and index-weighted products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_close <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
            r_s2_close <= r_s1_close;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_cross <= r_s1_cross;
        r_s2_mag   <= r_s1_mag;
        r_s2_sq    <= SQ_PROD_W'(r_s1_mag * r_s1_mag);
        r_s2_iw    <= r_s1_mag * r_s1_idx;
        r_s2_idx   <= r_s1_idx;
    end

    // Running totals including the beat in stage two.
    assign n_sq_sum      = r_sq_sum + SQ_SUM_W'(r_s2_sq);
    assign n_mag_sum     = r_mag_sum + MAG_SUM_W'(r_s2_mag);
    assign n_iw_sum      = r_iw_sum + IW_SUM_W'(r_s2_iw);
    assign n_cross_count = r_cross_count + COUNT_W'(r_s2_cross);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_sum      <= '0;
            r_mag_sum     <= '0;
            r_iw_sum      <= '0;
            r_cross_count <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_close) begin
                r_sq_sum      <= '0;
                r_mag_sum     <= '0;
                r_iw_sum      <= '0;
                r_cross_count <= '0;
            end else begin
                r_sq_sum      <= n_sq_sum;
                r_mag_sum     <= n_mag_sum;
                r_iw_sum      <= n_iw_sum;
                r_cross_count <= n_cross_count;
            end
        end
    end

    // Closed frame totals go to the queue.
    assign o_push              = r_s2_close;
    assign o_sum.n             = r_s2_idx + COUNT_W'(1);
    assign o_sum.sq_sum        = n_sq_sum;
    assign o_sum.mag_sum       = n_mag_sum;
    assign o_sum.iw_sum        = n_iw_sum;
    assign o_sum.cross_count   = n_cross_count;

endmodule

`default_nettype wire

// ----- rtl/avfc_queue.sv -----
// Small queue of closed-frame totals between the front end and the frame math.
`default_nettype none

module avfc_queue #(
    parameter int QUEUE_DEPTH = avfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_push,
    input  wire avfc_pkg::t_frame_sum                 i_data,
    input  wire logic                                 i_pop,
    output avfc_pkg::t_frame_sum                      o_data,
    output logic                                      o_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]          o_count
);
    import avfc_pkg::*;

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_frame_sum        r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_data  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

`ifndef NO_ASSERTIONS
    // The front end's slot reservation must keep a push away from a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("frame queue pushed while full");

    // The sequencer takes an entry only when one is there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("frame queue popped while empty");
`endif

endmodule

`default_nettype wire

// ----- rtl/avfc_back.sv -----
// Frame math: mean square by division, integer root, centroid and crossing tests, result.
`default_nettype none

module avfc_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire avfc_pkg::t_cfg                       i_cfg,
    input  wire avfc_pkg::t_frame_sum                 i_sum,
    input  wire logic                                 i_empty,
    output logic                                      o_pop,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [avfc_pkg::VISEME_W-1:0]             o_viseme,
    output logic [avfc_pkg::WEIGHT_W-1:0]             o_weight
);
    import avfc_pkg::*;

    t_back_state              r_state;
    t_back_state              n_state;
    logic [STEP_CNT_W-1:0]    r_cnt;
    logic [TEST_W-1:0]        r_step;

    logic [COUNT_W-1:0]       r_n;
    logic [MAG_SUM_W-1:0]     r_mag;
    logic [IW_SUM_W-1:0]      r_iw;
    logic [COUNT_W-1:0]       r_cc;
    logic [SQ_SUM_W-1:0]      r_div;
    logic [COUNT_W-1:0]       r_rem;
    logic [RAD_W-1:0]         r_rad;
    logic [SREM_W-1:0]        r_srem;
    logic [ROOT_W-1:0]        r_root;
    logic [NM_W-1:0]          r_nm;
    logic [PROD_W-1:0]        r_prod;
    logic [TEST_CNT-1:0]      r_hits;

    logic                     r_out_valid;
    logic [VISEME_W-1:0]      r_viseme;
    logic [WEIGHT_W-1:0]      r_weight;

    logic                     w_out_free;
    logic                     w_out_load;
    logic                     w_div_last;
    logic                     w_sqrt_last;

    logic [COUNT_W:0]         w_rem_sh;
    logic                     w_div_ge;
    logic [COUNT_W-1:0]       w_rem_next;
    logic [SQ_SUM_W-1:0]      w_div_next;

    logic [SREM_W+1:0]        w_srem_sh;
    logic [SREM_W+1:0]        w_trial;
    logic                     w_sqrt_ge;

    logic [LIMIT_W-1:0]       w_mul_a;
    logic [NM_W-1:0]          w_mul_b;
    logic                     w_hit;

    logic                     w_silent;
    logic [GAIN_PROD_W-1:0]   w_gain_prod;
    logic [WEIGHT_W-1:0]      w_weight;
    logic [VISEME_W-1:0]      w_viseme;

    assign w_out_free  = !r_out_valid || i_ready;
    assign w_div_last  = (r_cnt == STEP_CNT_W'(DIV_STEPS - 1));
    assign w_sqrt_last = (r_cnt == STEP_CNT_W'(SQRT_STEPS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (!i_empty)   n_state = ST_DIV;
            ST_DIV:   if (w_div_last) n_state = ST_SQRT;
            ST_SQRT:  if (w_sqrt_last) n_state = ST_NM;
            ST_NM:    n_state = ST_MULT;
            ST_MULT:  n_state = ST_TEST;
            ST_TEST:  n_state = (r_step == TST_CROSSING) ? ST_FINAL : ST_MULT;
            ST_FINAL: if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop      = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE:  o_pop      = !i_empty;
            ST_FINAL: w_out_load = w_out_free;
            default: begin
                o_pop      = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: r_cnt  <= '0;
                ST_DIV:  r_cnt  <= w_div_last ? '0 : r_cnt + STEP_CNT_W'(1);
                ST_SQRT: r_cnt  <= r_cnt + STEP_CNT_W'(1);
                ST_NM:   r_step <= TST_OPEN;
                ST_TEST: r_step <= r_step + TEST_W'(1);
                default: r_cnt  <= r_cnt;
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // One quotient bit per cycle of square_sum / n.
    assign w_rem_sh   = {r_rem, r_div[SQ_SUM_W-1]};
    assign w_div_ge   = (w_rem_sh >= {1'b0, r_n});
    assign w_rem_next = w_div_ge ? COUNT_W'(w_rem_sh - {1'b0, r_n}) : w_rem_sh[COUNT_W-1:0];
    assign w_div_next = {r_div[SQ_SUM_W-2:0], w_div_ge};

    // One root bit per cycle of the mean square.
    assign w_srem_sh = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_sqrt_ge = (w_srem_sh >= w_trial);

    // Shared limit multiplier: three centroid limits, then the crossing limit.
    always_comb begin
        case (r_step)
            TST_OPEN:  w_mul_a = i_cfg.limit_open;
            TST_MID:   w_mul_a = i_cfg.limit_mid;
            TST_ROUND: w_mul_a = i_cfg.limit_round;
            default:   w_mul_a = i_cfg.crossing_limit;
        endcase
    end
    assign w_mul_b = (r_step == TST_CROSSING) ? NM_W'(r_n - COUNT_W'(1)) : r_nm;

    // A frame of all-zero magnitudes has centroid zero: below any nonzero limit.
    always_comb begin
        if (r_step == TST_CROSSING) begin
            w_hit = (PROD_W'({r_cc, {FRAC_SHIFT{1'b0}}}) > r_prod);
        end else if (r_mag == '0) begin
            w_hit = (w_mul_a != '0);
        end else begin
            w_hit = (PROD_W'({r_iw, {FRAC_SHIFT{1'b0}}}) < r_prod);
        end
    end

    // Class and weight.
    assign w_silent    = (r_root < ROOT_W'(i_cfg.silence_level));
    assign w_gain_prod = i_cfg.weight_gain * r_root;
    always_comb begin
        if (w_gain_prod > GAIN_PROD_W'(WEIGHT_ONE)) begin
            w_weight = WEIGHT_W'(WEIGHT_ONE);
        end else begin
            w_weight = w_gain_prod[WEIGHT_W-1:0];
        end
        if (w_silent) begin
            w_viseme = VIS_SILENCE;
            w_weight = '0;
        end else if (r_hits[TST_OPEN]) begin
            w_viseme = VIS_AA;
        end else if (r_hits[TST_MID]) begin
            w_viseme = VIS_E;
        end else if (r_hits[TST_ROUND]) begin
            w_viseme = VIS_O;
        end else if (r_hits[TST_CROSSING]) begin
            w_viseme = VIS_SS;
        end else begin
            w_viseme = VIS_I;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_n   <= i_sum.n;
                    r_mag <= i_sum.mag_sum;
                    r_iw  <= i_sum.iw_sum;
                    r_cc  <= i_sum.cross_count;
                    r_div <= i_sum.sq_sum;
                    r_rem <= '0;
                end
            end
            ST_DIV: begin
                r_div <= w_div_next;
                r_rem <= w_rem_next;
                if (w_div_last) begin
                    r_rad  <= w_div_next[RAD_W-1:0];
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_srem <= w_sqrt_ge ? SREM_W'(w_srem_sh - w_trial) : SREM_W'(w_srem_sh);
                r_root <= {r_root[ROOT_W-2:0], w_sqrt_ge};
            end
            ST_NM:   r_nm   <= r_n * r_mag;
            ST_MULT: r_prod <= w_mul_a * w_mul_b;
            ST_TEST: r_hits[r_step] <= w_hit;
            default: r_prod <= r_prod;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_viseme <= w_viseme;
            r_weight <= w_weight;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_viseme = r_viseme;
    assign o_weight = r_weight;

`ifndef NO_ASSERTIONS
    // The front end never closes an empty frame, so the divisor is never zero.
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_n != '0))
        else $error("frame divide started with zero sample count");

    // Loading a result returns the sequencer to idle with the result shown.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("result load did not reach the output register");

    // A silent result carries no weight, and no weight exceeds one.
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_weight <= WEIGHT_W'(WEIGHT_ONE))
                      && ((r_viseme != VIS_SILENCE) || (r_weight == '0))))
        else $error("result weight out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/audio_frame_viseme_classifier.sv -----
// Audio frame viseme classifier top level: configuration registers, front end, queue, frame math.
// Throughput: one sample beat per cycle while the frame queue has room. The frame math works on
// one frame at a time: an issue state, 43 divide steps, 16 root steps, one product, four
// multiply-and-test pairs, one load. Frame totals reach it via the front-end stages and the queue.
// Frames shorter than the frame math time fill the frame queue and then pause the sample input.
// Reset (synchronous, active low) clears accumulators, queue, sequencer and loads register defaults.
`default_nettype none

module audio_frame_viseme_classifier #(
    parameter int FRAME_MAX   = avfc_pkg::FRAME_MAX_DEF,
    parameter int QUEUE_DEPTH = avfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Sample stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [avfc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // [15:0] sample
    input  wire logic                                  s_axis_tlast,   // last sample of frame
    // Result stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [avfc_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,   // [2:0] viseme, [18:3] weight
    // Configuration writes
    input  wire logic                                  i_cfg_we,
    input  wire logic [avfc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [avfc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import avfc_pkg::*;

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg                  r_cfg;
    t_frame_sum            w_push_sum;
    t_frame_sum            w_head_sum;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_empty;
    logic [QCNT_W-1:0]     w_queue_count;
    logic [VISEME_W-1:0]   w_viseme;
    logic [WEIGHT_W-1:0]   w_weight;

    // Configuration registers, masked to their widths; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_level  <= SILENCE_LEVEL_RST;
            r_cfg.limit_open     <= LIMIT_OPEN_RST;
            r_cfg.limit_mid      <= LIMIT_MID_RST;
            r_cfg.limit_round    <= LIMIT_ROUND_RST;
            r_cfg.crossing_limit <= CROSSING_LIMIT_RST;
            r_cfg.weight_gain    <= WEIGHT_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SILENCE_LEVEL:  r_cfg.silence_level  <= i_cfg_data[LEVEL_W-1:0];
                CFG_LIMIT_OPEN:     r_cfg.limit_open     <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_MID:      r_cfg.limit_mid      <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_ROUND:    r_cfg.limit_round    <= i_cfg_data[LIMIT_W-1:0];
                CFG_CROSSING_LIMIT: r_cfg.crossing_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_WEIGHT_GAIN:    r_cfg.weight_gain    <= i_cfg_data[GAIN_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // Per-sample accumulation
    avfc_front #(
        .FRAME_MAX   (FRAME_MAX),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      (signed'(s_axis_tdata[SAMPLE_W-1:0])),
        .i_last        (s_axis_tlast),
        .i_queue_count (w_queue_count),
        .o_push        (w_push),
        .o_sum         (w_push_sum)
    );

    // Closed frames waiting for the frame math
    avfc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_sum),
        .i_pop   (w_pop),
        .o_data  (w_head_sum),
        .o_empty (w_empty),
        .o_count (w_queue_count)
    );

    // Classification and weight
    avfc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_sum    (w_head_sum),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_viseme (w_viseme),
        .o_weight (w_weight)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - WEIGHT_W - VISEME_W){1'b0}}, w_weight, w_viseme};

endmodule

`default_nettype wire
